FILE: hw/rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants of the spanning-tree learning bridge.
// ----------------------------------------------------------------------------
package stp_pkg;

	localparam logic [15:0] COST_MAX = 16'd65534;

	typedef enum logic [1:0] {
		CMD_BPDU  = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_HELLO = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [0:0] {
		REG_OWN_ID  = 1'b0,
		REG_PRESENT = 1'b1
	} reg_idx_t;

	// lexicographic a < b over (root, cost, sender)
	function automatic logic lex_less(input logic [15:0] a1, input logic [15:0] a2,
		input logic [15:0] a3, input logic [15:0] b1, input logic [15:0] b2,
		input logic [15:0] b3);
		if (a1 != b1) return a1 < b1;
		if (a2 != b2) return a2 < b2;
		return a3 < b3;
	endfunction

endpackage

FILE: hw/rtl/stp_host_table.sv
// ----------------------------------------------------------------------------
// stp_host_table
// Host-to-port memory with a clearing sweep after reset.
// One read port and one write port, read data registered.
// ----------------------------------------------------------------------------
module stp_host_table #(
	parameter int NUM_HOSTS = 256,
	parameter int EW        = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [$clog2(NUM_HOSTS)-1:0] raddr,
	output logic [EW-1:0]                rdata,
	input  logic                         we,
	input  logic [$clog2(NUM_HOSTS)-1:0] waddr,
	input  logic [EW-1:0]                wdata,
	output logic                         clearing
);
	localparam int AW = $clog2(NUM_HOSTS);

	logic [EW-1:0] mem [NUM_HOSTS];
	logic [AW:0]   clr_cnt_q;

	assign clearing = (clr_cnt_q < (AW+1)'(NUM_HOSTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clearing) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			mem[clr_cnt_q[AW-1:0]] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/stp_learning_bridge.sv
// ----------------------------------------------------------------------------
// stp_learning_bridge
// Spanning-tree bridge port logic with host learning.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one event item: BPDU, data frame or hello tick. m_axis
//  returns exactly one result item per event: send mask plus the bridge's
//  advertised BPDU and port roles after the event.
//  Timing: the host memory is read at the accepting edge, its data is used in
//  the next cycle and the result is registered at the end of that cycle once
//  the output register is free. s_axis_tready stays low while an item sits in
//  the lookup stage, so the learning write lands before the next read; a new
//  item is taken only after the last one has left the lookup stage.
//  The result register decouples the sides: a new item is accepted while a
//  finished result still waits, and that item is held in the lookup stage
//  until the output register frees; the host memory is re-read every cycle
//  while it is held.
//  Reset: roles and port records are cleared at once; the host memory is
//  swept one entry per cycle while s_axis_tready is low.
//  APB writes are taken at all times; registers read back.
//  Source learning and destination lookup use two copies of the host memory,
//  one per read address, written together: a frame whose destination is its
//  own source sees the fresh entry through forwarding.
// ----------------------------------------------------------------------------
module stp_learning_bridge #(
	parameter int NUM_PORTS = 8,
	parameter int NUM_HOSTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] command [4:2] arrival_port [20:5] received_root_id
	// [36:21] received_cost [52:37] sender_id [60:53] source_host
	// [68:61] dest_host, [71:69] zero
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] send_mask [23:8] bpdu_root_id [39:24] bpdu_cost
	// [55:40] bpdu_sender_id [63:56] designated_mask
	// [66:64] root_port_index [67] root_port_valid, [71:68] zero
	output logic [71:0] m_axis_tdata
);
	import stp_pkg::*;

	localparam int NP = (NUM_PORTS < 8) ? NUM_PORTS : 8;
	localparam int HW = $clog2(NUM_HOSTS);
	localparam int EW = 4;

	// configuration
	logic [15:0] own_id_q;
	logic [7:0]  present_q;
	logic        cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q  <= '0;
			present_q <= 8'hFF;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_OWN_ID:  own_id_q <= pwdata[15:0];
				REG_PRESENT: present_q <= pwdata[7:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx_t'(paddr[2]))
			REG_OWN_ID:  prdata = {16'd0, own_id_q};
			REG_PRESENT: prdata = {24'd0, present_q};
			default:     prdata = '0;
		endcase
	end

	logic [7:0] present_m;
	always_comb begin
		present_m = '0;
		for (int i = 0; i < NP; i++) present_m[i] = present_q[i];
	end

	// spanning tree state
	logic        root_self_q;
	logic [15:0] best_root_q, best_cost_q, best_sender_q, adv_cost_q;
	logic [2:0]  best_port_q;
	logic [7:0]  rec_valid_q;
	logic [15:0] rec_root_q [8];
	logic [15:0] rec_cost_q [8];
	logic [15:0] rec_sender_q [8];

	// stage 1: accepted item waiting for host memory data
	logic        v_s1;
	logic [71:0] d_s1;
	logic        out_free, go_s1, clearing;
	logic        clearing_tab, clearing_src;
	logic        m_valid_q;
	logic [71:0] m_data_q;

	assign clearing      = clearing_tab || clearing_src;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign go_s1         = v_s1 && out_free;
	// no accept while the lookup stage is busy: its learning write must land
	// before the next item's read
	assign s_axis_tready = !clearing && !v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end else if (go_s1) begin
			v_s1 <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) d_s1 <= s_axis_tdata;
	end

	// the memory read address follows the incoming item; hold while stalled
	logic [7:0]    dst_in;
	logic [HW-1:0] raddr;
	logic [EW-1:0] rdata;
	assign dst_in = (s_axis_tready && s_axis_tvalid) ? s_axis_tdata[68:61] : d_s1[68:61];
	assign raddr  = HW'(dst_in);

	// decode stage-1 item
	cmd_t        cmd;
	logic [2:0]  port;
	logic [15:0] r_root, r_cost, r_sender;
	logic [7:0]  src, dst;
	logic        port_ok;
	assign cmd      = cmd_t'(d_s1[1:0]);
	assign port     = d_s1[4:2];
	assign r_root   = d_s1[20:5];
	assign r_cost   = d_s1[36:21];
	assign r_sender = d_s1[52:37];
	assign src      = d_s1[60:53];
	assign dst      = d_s1[68:61];
	assign port_ok  = present_m[port];

	logic src_in, dst_in_rng;
	assign src_in     = 32'(src) < NUM_HOSTS;
	assign dst_in_rng = 32'(dst) < NUM_HOSTS;

	// learning write; written read-data only feeds this item
	logic          learn_we;
	logic [EW-1:0] src_entry;
	logic          src_learned;
	assign learn_we = go_s1 && cmd == CMD_DATA && port_ok && src_in && !src_learned;

	// source entry: the table has a single read port, so the source is read in the
	// lookup stage from a second copy of the memory, also a registered read
	logic [EW-1:0] mem_src_q;
	stp_host_table #(.NUM_HOSTS(NUM_HOSTS), .EW(EW)) u_tab (
		.clk(clk), .arst_n(arst_n), .raddr(raddr), .rdata(rdata),
		.we(learn_we), .waddr(HW'(src)), .wdata(EW'({1'b0, port} + 4'd1)),
		.clearing(clearing_tab));

	// second copy of the host memory, read at the source address
	stp_host_table #(.NUM_HOSTS(NUM_HOSTS), .EW(EW)) u_src (
		.clk(clk), .arst_n(arst_n),
		.raddr(HW'((s_axis_tready && s_axis_tvalid) ? s_axis_tdata[60:53] : d_s1[60:53])),
		.rdata(mem_src_q), .we(learn_we), .waddr(HW'(src)),
		.wdata(EW'({1'b0, port} + 4'd1)), .clearing(clearing_src));
	assign src_entry   = mem_src_q;
	assign src_learned = src_entry != '0;

	// destination entry with forwarding of the same item's learning
	logic [EW-1:0] dst_entry;
	always_comb begin
		dst_entry = '0;
		if (dst_in_rng) begin
			dst_entry = rdata;
			if (src_in && src == dst && !src_learned)
				dst_entry = EW'({1'b0, port} + 4'd1);
		end
	end

	// BPDU update
	logic        rec_upd, beats;
	logic        n_root_self;
	logic [15:0] n_best_root, n_best_cost, n_best_sender, n_adv_cost;
	logic [2:0]  n_best_port;
	logic [7:0]  n_rec_valid;
	logic [15:0] n_rec_root [8];
	logic [15:0] n_rec_cost [8];
	logic [15:0] n_rec_sender [8];

	always_comb begin
		rec_upd = !rec_valid_q[port] || lex_less(r_root, r_cost, r_sender,
			rec_root_q[port], rec_cost_q[port], rec_sender_q[port]);
		if (root_self_q) beats = r_root < own_id_q;
		else if (r_root != best_root_q || r_cost != best_cost_q || r_sender != best_sender_q)
			beats = lex_less(r_root, r_cost, r_sender, best_root_q, best_cost_q, best_sender_q);
		else beats = port < best_port_q;

		n_root_self = root_self_q; n_best_root = best_root_q; n_best_cost = best_cost_q;
		n_best_sender = best_sender_q; n_best_port = best_port_q; n_adv_cost = adv_cost_q;
		n_rec_valid = rec_valid_q;
		for (int i = 0; i < 8; i++) begin
			n_rec_root[i] = rec_root_q[i]; n_rec_cost[i] = rec_cost_q[i];
			n_rec_sender[i] = rec_sender_q[i];
		end
		if (cmd == CMD_BPDU && port_ok) begin
			if (rec_upd) begin
				n_rec_valid[port] = 1'b1;
				n_rec_root[port] = r_root; n_rec_cost[port] = r_cost;
				n_rec_sender[port] = r_sender;
			end
			if (beats) begin
				n_root_self = 1'b0; n_best_root = r_root; n_best_cost = r_cost;
				n_best_sender = r_sender; n_best_port = port;
				n_adv_cost = (r_cost >= COST_MAX) ? COST_MAX : r_cost + 16'd1;
			end
		end
	end

	// designated ports after the event
	function automatic logic [7:0] desig(input logic rs, input logic [15:0] br,
		input logic [15:0] ac, input logic [15:0] own, input logic [7:0] pm,
		input logic [7:0] vv, input logic [15:0] rr [8], input logic [15:0] rc [8],
		input logic [15:0] rsn [8]);
		logic [7:0] m;
		logic [15:0] ar, acc;
		m = '0;
		ar = rs ? own : br;
		acc = rs ? 16'd0 : ac;
		for (int p = 0; p < 8; p++)
			m[p] = pm[p] && (!vv[p] || lex_less(ar, acc, own, rr[p], rc[p], rsn[p]));
		return m;
	endfunction

	logic [7:0] desig_new, send;
	assign desig_new = desig(n_root_self, n_best_root, n_adv_cost, own_id_q, present_m,
		n_rec_valid, n_rec_root, n_rec_cost, n_rec_sender);

	always_comb begin
		send = '0;
		case (cmd)
			CMD_HELLO: send = desig_new;
			CMD_DATA: if (port_ok) begin
				if (dst_entry != '0 && 32'(dst_entry) <= NP) send = 8'(1) << (dst_entry - 1'b1);
				else begin
					send = desig_new;
					if (!root_self_q) send[best_port_q] = 1'b1;
				end
				send = send & present_m;
				send[port] = 1'b0;
			end
			default: send = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_self_q <= 1'b1;
			best_root_q <= '0; best_cost_q <= '0; best_sender_q <= '0;
			best_port_q <= '0; adv_cost_q <= '0; rec_valid_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (go_s1) begin
				root_self_q <= n_root_self; best_root_q <= n_best_root;
				best_cost_q <= n_best_cost; best_sender_q <= n_best_sender;
				best_port_q <= n_best_port; adv_cost_q <= n_adv_cost;
				rec_valid_q <= n_rec_valid;
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			for (int i = 0; i < 8; i++) begin
				rec_root_q[i] <= n_rec_root[i]; rec_cost_q[i] <= n_rec_cost[i];
				rec_sender_q[i] <= n_rec_sender[i];
			end
			m_data_q <= {4'd0, !n_root_self, n_root_self ? 3'd0 : n_best_port, desig_new,
				own_id_q, n_root_self ? 16'd0 : n_adv_cost,
				n_root_self ? own_id_q : n_best_root, send};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_axis_tready) else $error("item taken during clear");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_axis_tready |=> m_valid_q) else $error("result dropped");
	a_learn_data: assert property (@(posedge clk) disable iff (!arst_n)
		learn_we |-> go_s1 && cmd == CMD_DATA) else $error("stray learn write");
	a_root_port: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_data_q[67] || m_data_q[66:64] == 3'd0)) else $error("root port");
endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stp_learning_bridge: random BPDU, data and hello
// events against a behavioral predictor, APB setup between phases.
// ----------------------------------------------------------------------------
module testbench;
	import stp_pkg::*;

	typedef struct packed {
		logic [7:0]  dest_host;
		logic [7:0]  source_host;
		logic [15:0] sender_id;
		logic [15:0] received_cost;
		logic [15:0] received_root_id;
		logic [2:0]  arrival_port;
		cmd_t        command;
	} event_t;

	typedef struct packed {
		logic        root_port_valid;
		logic [2:0]  root_port_index;
		logic [7:0]  designated_mask;
		logic [15:0] bpdu_sender_id;
		logic [15:0] bpdu_cost;
		logic [15:0] bpdu_root_id;
		logic [7:0]  send_mask;
	} status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;

	stp_learning_bridge u_dut (.*);

	always #6 clk = ~clk;

	// predictor state
	logic [15:0] own_id;
	logic [7:0]  present;
	logic        self_root;
	logic [15:0] best_root, best_cost, best_sender, adv_cost;
	logic [2:0]  best_port;
	logic        rec_valid [8];
	logic [15:0] rec_root [8], rec_cost [8], rec_sender [8];
	logic [3:0]  host_port [256];

	event_t  pending_events[$];
	status_t expected_status[$];
	int      errors = 0;
	int      idle_cycles = 0;
	int      hold_off = 0;
	bit      took = 0;

	function automatic logic less3(logic [15:0] a1, a2, a3, b1, b2, b3);
		if (a1 != b1) return a1 < b1;
		if (a2 != b2) return a2 < b2;
		return a3 < b3;
	endfunction

	function automatic logic [15:0] cur_root();
		return self_root ? own_id : best_root;
	endfunction

	function automatic logic [15:0] cur_cost();
		return self_root ? 16'd0 : adv_cost;
	endfunction

	function automatic logic [7:0] designated();
		logic [7:0] m;
		m = '0;
		for (int p = 0; p < 8; p++)
			if (present[p] && (!rec_valid[p] || less3(cur_root(), cur_cost(), own_id,
					rec_root[p], rec_cost[p], rec_sender[p])))
				m[p] = 1'b1;
		return m;
	endfunction

	// apply one event to the bridge state and return the status it reports
	function automatic status_t bridge_event(event_t e);
		status_t r;
		logic [7:0] m;
		logic beats;
		logic [3:0] entry;
		int p;
		p = e.arrival_port;
		m = '0;
		if (e.command == CMD_BPDU && present[p]) begin
			if (!rec_valid[p] || less3(e.received_root_id, e.received_cost, e.sender_id,
					rec_root[p], rec_cost[p], rec_sender[p])) begin
				rec_valid[p] = 1'b1;
				rec_root[p] = e.received_root_id;
				rec_cost[p] = e.received_cost;
				rec_sender[p] = e.sender_id;
			end
			if (self_root)
				beats = e.received_root_id < own_id;
			else if (e.received_root_id != best_root || e.received_cost != best_cost
					|| e.sender_id != best_sender)
				beats = less3(e.received_root_id, e.received_cost, e.sender_id,
					best_root, best_cost, best_sender);
			else
				beats = p < best_port;
			if (beats) begin
				self_root = 1'b0;
				best_root = e.received_root_id;
				best_cost = e.received_cost;
				best_sender = e.sender_id;
				best_port = e.arrival_port;
				adv_cost = (e.received_cost >= COST_MAX) ? COST_MAX
					: e.received_cost + 16'd1;
			end
		end else if (e.command == CMD_DATA && present[p]) begin
			if (host_port[e.source_host] == 4'd0)
				host_port[e.source_host] = {1'b0, e.arrival_port} + 4'd1;
			entry = host_port[e.dest_host];
			if (entry != 4'd0) begin
				m = 8'd1 << (entry - 4'd1);
			end else begin
				m = designated();
				if (!self_root)
					m[best_port] = 1'b1;
			end
			m = m & present;
			m[p] = 1'b0;
		end else if (e.command == CMD_HELLO) begin
			m = designated();
		end
		r.send_mask = m;
		r.bpdu_root_id = cur_root();
		r.bpdu_cost = cur_cost();
		r.bpdu_sender_id = own_id;
		r.designated_mask = designated();
		r.root_port_index = self_root ? 3'd0 : best_port;
		r.root_port_valid = !self_root;
		return r;
	endfunction

	// sender: one item per handshake, random gaps
	int send_gap = 0;
	always @(negedge clk) begin
		if (took || !s_axis_tvalid) begin
			took = 0;
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_events.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {3'b0, pending_events[0]};
				send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
					: ($urandom_range(0, 2) == 0 ? $urandom_range(0, 2) : 0);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long forced hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 29) == 0) begin
			hold_off = $urandom_range(5, 25);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		status_t got, want;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Simulation FAILED");
			$finish;
		end
		if (s_axis_tvalid && s_axis_tready) begin
			expected_status.push_back(bridge_event(event_t'(s_axis_tdata[68:0])));
			void'(pending_events.pop_front());
			took = 1;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = status_t'(m_axis_tdata[67:0]);
			if (expected_status.size() == 0) begin
				$error("result with no expected status: %h", got);
				errors++;
			end else begin
				want = expected_status.pop_front();
				if (got.send_mask != want.send_mask) begin
					$error("send_mask exp %h got %h", want.send_mask, got.send_mask); errors++; end
				if (got.bpdu_root_id != want.bpdu_root_id) begin
					$error("bpdu_root_id exp %h got %h", want.bpdu_root_id, got.bpdu_root_id);
					errors++; end
				if (got.bpdu_cost != want.bpdu_cost) begin
					$error("bpdu_cost exp %h got %h", want.bpdu_cost, got.bpdu_cost); errors++; end
				if (got.bpdu_sender_id != want.bpdu_sender_id) begin
					$error("bpdu_sender_id exp %h got %h", want.bpdu_sender_id,
						got.bpdu_sender_id); errors++; end
				if (got.designated_mask != want.designated_mask) begin
					$error("designated_mask exp %h got %h", want.designated_mask,
						got.designated_mask); errors++; end
				if (got.root_port_index != want.root_port_index) begin
					$error("root_port_index exp %h got %h", want.root_port_index,
						got.root_port_index); errors++; end
				if (got.root_port_valid != want.root_port_valid) begin
					$error("root_port_valid exp %h got %h", want.root_port_valid,
						got.root_port_valid); errors++; end
			end
		end
	end

	task automatic apb_write(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_OWN_ID) own_id = value[15:0];
		else present = value[7:0];
	endtask

	// wait until all queued items went in and all results came out
	task automatic drain();
		while (pending_events.size() > 0 || expected_status.size() > 0 || s_axis_tvalid)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	function automatic event_t rand_event(int bias);
		event_t e;
		e.command = cmd_t'(($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2));
		e.arrival_port = 3'($urandom_range(0, 7));
		// small id space so ties and record replacement happen often
		e.received_root_id = 16'(bias ? $urandom_range(0, 12) : $urandom_range(0, 65535));
		e.received_cost = 16'(($urandom_range(0, 7) == 0) ? 65535 - $urandom_range(0, 2)
			: (bias ? $urandom_range(0, 6) : $urandom_range(0, 65535)));
		e.sender_id = 16'(bias ? $urandom_range(0, 8) : $urandom_range(0, 65535));
		e.source_host = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
			: $urandom_range(0, 15));
		e.dest_host = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
			: $urandom_range(0, 15));
		return e;
	endfunction

	function automatic event_t mk(cmd_t c, int p, int r, int k, int s, int sh, int dh);
		event_t e;
		e.command = c; e.arrival_port = 3'(p); e.received_root_id = 16'(r);
		e.received_cost = 16'(k); e.sender_id = 16'(s); e.source_host = 8'(sh);
		e.dest_host = 8'(dh);
		return e;
	endfunction

	initial begin
		own_id = 16'd0; present = 8'hFF; self_root = 1'b1;
		best_root = '0; best_cost = '0; best_sender = '0; best_port = '0; adv_cost = '0;
		for (int i = 0; i < 8; i++) begin
			rec_valid[i] = 1'b0; rec_root[i] = '0; rec_cost[i] = '0; rec_sender[i] = '0;
		end
		for (int i = 0; i < 256; i++) host_port[i] = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		apb_write(REG_OWN_ID, 32'd100);
		apb_write(REG_PRESENT, 32'h7F);
		// directed: hello, cost saturation, ties, absent port, unknown, self-forward
		pending_events.push_back(mk(CMD_HELLO, 0, 0, 0, 0, 0, 0));
		pending_events.push_back(mk(CMD_BPDU, 3, 200, 5, 9, 0, 0));
		pending_events.push_back(mk(CMD_BPDU, 2, 50, 65535, 65535, 0, 0));
		pending_events.push_back(mk(CMD_BPDU, 1, 50, 65534, 7, 0, 0));
		pending_events.push_back(mk(CMD_BPDU, 0, 50, 65534, 7, 0, 0));
		pending_events.push_back(mk(CMD_BPDU, 4, 50, 65534, 7, 0, 0));
		pending_events.push_back(mk(CMD_BPDU, 7, 0, 0, 0, 0, 0));
		pending_events.push_back(mk(CMD_DATA, 7, 0, 0, 0, 1, 2));
		pending_events.push_back(mk(CMD_NONE, 5, 65535, 65535, 65535, 255, 255));
		pending_events.push_back(mk(CMD_DATA, 5, 0, 0, 0, 255, 255));
		pending_events.push_back(mk(CMD_DATA, 6, 0, 0, 0, 0, 255));
		pending_events.push_back(mk(CMD_DATA, 2, 0, 0, 0, 255, 0));
		pending_events.push_back(mk(CMD_HELLO, 7, 0, 0, 0, 0, 0));
		pending_events.push_back(mk(CMD_BPDU, 5, 0, 0, 0, 0, 0));
		pending_events.push_back(mk(CMD_HELLO, 0, 0, 0, 0, 0, 0));
		drain();
		// long receiver hold-off while the sender keeps offering
		for (int i = 0; i < 10; i++) pending_events.push_back(rand_event(1));
		hold_off = 60;
		drain();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin apb_write(REG_OWN_ID, 32'd0); apb_write(REG_PRESENT, 32'hFF); end
				1: begin apb_write(REG_OWN_ID, 32'd65534); apb_write(REG_PRESENT, 32'h00); end
				2: begin apb_write(REG_OWN_ID, 32'd6); apb_write(REG_PRESENT, 32'hA5); end
				default: begin
					apb_write(REG_OWN_ID, $urandom_range(0, 65535));
					apb_write(REG_PRESENT, $urandom_range(0, 255));
				end
			endcase
			for (int i = 0; i < (phase == 1 ? 30 : 180); i++)
				pending_events.push_back(rand_event($urandom_range(0, 4) != 0));
			drain();
		end
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
